FILE: hw/rtl/tte_pkg.sv
// Package for the tap tempo estimator: item types, register indexes, constants
// and the tempo clamp function.
// Depends on nothing; the top level and the testbench import it.
`default_nettype none

package tte_pkg;

    localparam int TIME_BITS     = 48;
    localparam int TEMPO_BITS    = 10;
    localparam int REQ_BITS      = 16;
    localparam int HELD_BITS     = 4;
    localparam int GAP_BITS      = 24;
    localparam int CFG_IDX_BITS  = 2;
    localparam int HISTORY_DEPTH = 12;

    localparam logic [TIME_BITS-1:0]  MINUTE_US     = TIME_BITS'(60000000);
    localparam logic [TEMPO_BITS-1:0] TEMPO_RESET   = TEMPO_BITS'(120);
    localparam logic [TEMPO_BITS-1:0] TEMPO_MIN_RST = TEMPO_BITS'(30);
    localparam logic [TEMPO_BITS-1:0] TEMPO_MAX_RST = TEMPO_BITS'(300);
    localparam logic [GAP_BITS-1:0]   MAX_GAP_RST   = GAP_BITS'(2000000);

    localparam logic [CFG_IDX_BITS-1:0] REG_TEMPO_MIN   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TEMPO_MAX   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_TAP_GAP = 2'd2;

    localparam logic MODE_TAP = 1'b0;
    localparam logic MODE_SET = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [TIME_BITS-1:0]  tap_time;
        logic [REQ_BITS-1:0]   requested_tempo;
    } tte_in_t;

    typedef struct packed {
        logic [TEMPO_BITS-1:0] tempo;
        logic                  tempo_changed;
        logic [HELD_BITS-1:0]  taps_held;
    } tte_out_t;

    // Raise to the minimum first, then lower to the maximum.
    function automatic logic [TEMPO_BITS-1:0] clamp_tempo(
        input logic [TEMPO_BITS-1:0] t,
        input logic [TEMPO_BITS-1:0] tmin,
        input logic [TEMPO_BITS-1:0] tmax
    );
        logic [TEMPO_BITS-1:0] v;
        v = (t < tmin) ? tmin : t;
        v = (v > tmax) ? tmax : v;
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tte_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module tte_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 12
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tte_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; a division by zero returns an all-ones quotient.
`default_nettype none

module tte_div #(
    parameter int W = 48
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic      [W-1:0] quotient
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg;
    logic [W-1:0]  dsr_reg;
    logic [W:0]    rem_reg;
    logic [CW-1:0] count_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W:0]    rem_shift;
    logic          fits;

    assign rem_shift = {rem_reg[W-1:0], quo_reg[W-1]};
    assign fits      = (rem_shift >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CW'(W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_shift - {1'b0, dsr_reg}) : rem_shift;
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tap_tempo_estimator.sv
// Tap tempo estimator top level: tap history ring, sequencer and result register.
// Depends on tte_pkg, tte_ram and tte_div.
//
//   Channel   Signals                       Direction  Item
//   tap       tap_valid/tap_ready/tap_item   in         tte_in_t
//   res       res_valid/res_ready/res_item   out        tte_out_t
//   cfg       cfg_we/cfg_index/cfg_data      in         register write
//
// A tap that completes a window of two or more presses runs two divisions on the
// shared bit-serial divider: span over the number of intervals, then one minute
// over the average interval. Other taps and direct sets skip the divider.
// One item is in work at a time; the next is taken while the result register
// still waits for res_ready. Reset is asynchronous and needs no clearing pass;
// the history ring is not reset.
`default_nettype none

module tap_tempo_estimator #(
    parameter int HISTORY_DEPTH = tte_pkg::HISTORY_DEPTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                tap_valid,
    output logic                                     tap_ready,
    input  wire tte_pkg::tte_in_t                    tap_item,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output tte_pkg::tte_out_t                        res_item,
    input  wire logic                                cfg_we,
    input  wire logic [tte_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [tte_pkg::GAP_BITS-1:0]        cfg_data
);

    import tte_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SET  = 3'd1;
    localparam logic [2:0] ST_TAP  = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_DIV1 = 3'd4;
    localparam logic [2:0] ST_DIV2 = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;

    logic [TEMPO_BITS-1:0] tempo_min_reg;
    logic [TEMPO_BITS-1:0] tempo_max_reg;
    logic [GAP_BITS-1:0]   max_gap_reg;

    tte_in_t               item_reg;
    logic [TIME_BITS-1:0]  last_tap_reg;
    logic [AW-1:0]         write_slot_reg;
    logic [FW-1:0]         fill_reg;
    logic [TEMPO_BITS-1:0] tempo_reg;
    logic                  changed_reg;

    logic                  res_valid_reg;
    tte_out_t              res_item_reg;

    // Tap bookkeeping for the current item.
    logic [TIME_BITS-1:0]  gap;
    logic                  new_seq;
    logic [AW-1:0]         slot_eff;
    logic [AW-1:0]         slot_inc;
    logic [FW-1:0]         fill_eff;
    logic [FW-1:0]         fill_inc;
    logic [AW-1:0]         oldest;
    logic                  ring_we;
    logic                  ring_re;
    logic [TIME_BITS-1:0]  ring_rdata;

    logic                  div_start;
    logic [TIME_BITS-1:0]  div_dividend;
    logic [TIME_BITS-1:0]  div_divisor;
    logic                  div_done;
    logic [TIME_BITS-1:0]  div_quotient;
    logic [TEMPO_BITS-1:0] quo_sat;
    logic [TEMPO_BITS-1:0] req_sat;
    logic                  res_load;

    assign gap      = item_reg.tap_time - last_tap_reg;
    assign new_seq  = (last_tap_reg == '0) || (gap >= TIME_BITS'(max_gap_reg));
    assign slot_eff = new_seq ? '0 : write_slot_reg;
    assign fill_eff = new_seq ? '0 : fill_reg;
    assign slot_inc = (slot_eff == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_eff + AW'(1);
    assign fill_inc = (fill_eff < FW'(HISTORY_DEPTH)) ? fill_eff + FW'(1) : fill_eff;
    // Until the window is full the oldest press sits in slot zero.
    assign oldest   = (fill_inc < FW'(HISTORY_DEPTH)) ? '0 : slot_inc;
    assign ring_we  = (state_reg == ST_TAP);
    assign ring_re  = (state_reg == ST_TAP);

    tte_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (slot_eff),
        .wdata (item_reg.tap_time),
        .re    (ring_re),
        .raddr (oldest),
        .rdata (ring_rdata)
    );

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = item_reg.tap_time - ring_rdata;
        div_divisor  = TIME_BITS'(fill_reg - FW'(1));
        if (state_reg == ST_READ)
        begin
            div_start = 1'b1;
        end
        else if (state_reg == ST_DIV1)
        begin
            div_start    = div_done;
            div_dividend = MINUTE_US;
            div_divisor  = div_quotient;
        end
    end

    tte_div #(
        .W (TIME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Values beyond the tempo width saturate before the clamp.
    assign quo_sat = (|div_quotient[TIME_BITS-1:TEMPO_BITS]) ? '1
                                                            : div_quotient[TEMPO_BITS-1:0];
    assign req_sat = (|item_reg.requested_tempo[REQ_BITS-1:TEMPO_BITS]) ? '1
                     : item_reg.requested_tempo[TEMPO_BITS-1:0];

    assign res_load = (state_reg == ST_DONE) && (!res_valid_reg || res_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tap_valid)
                begin
                    state_next = (tap_item.mode == MODE_SET) ? ST_SET : ST_TAP;
                end
            end
            ST_SET:  state_next = ST_DONE;
            ST_TAP:  state_next = (fill_inc >= FW'(2)) ? ST_READ : ST_DONE;
            ST_READ: state_next = ST_DIV1;
            ST_DIV1:
            begin
                if (div_done)
                begin
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tempo_min_reg  <= TEMPO_MIN_RST;
            tempo_max_reg  <= TEMPO_MAX_RST;
            max_gap_reg    <= MAX_GAP_RST;
            last_tap_reg   <= '0;
            write_slot_reg <= '0;
            fill_reg       <= '0;
            tempo_reg      <= TEMPO_RESET;
            changed_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TEMPO_MIN:   tempo_min_reg <= cfg_data[TEMPO_BITS-1:0];
                    REG_TEMPO_MAX:   tempo_max_reg <= cfg_data[TEMPO_BITS-1:0];
                    REG_MAX_TAP_GAP: max_gap_reg   <= cfg_data;
                    default:         ;
                endcase
            end

            unique case (state_reg)
                ST_SET:
                begin
                    tempo_reg   <= clamp_tempo(req_sat, tempo_min_reg, tempo_max_reg);
                    changed_reg <= 1'b1;
                end
                ST_TAP:
                begin
                    last_tap_reg   <= item_reg.tap_time;
                    write_slot_reg <= slot_inc;
                    fill_reg       <= fill_inc;
                    changed_reg    <= 1'b0;
                end
                ST_DIV2:
                begin
                    if (div_done)
                    begin
                        tempo_reg   <= clamp_tempo(quo_sat, tempo_min_reg, tempo_max_reg);
                        changed_reg <= 1'b1;
                    end
                end
                default: ;
            endcase

            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tap_valid && tap_ready)
        begin
            item_reg <= tap_item;
        end
        if (res_load)
        begin
            res_item_reg.tempo         <= tempo_reg;
            res_item_reg.tempo_changed <= changed_reg;
            res_item_reg.taps_held     <= HELD_BITS'(fill_reg);
        end
    end

    assign tap_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

`default_nettype wire

FILE: tb/tap_tempo_estimator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tap_tempo_estimator: directed tap and set items,
// register settings and random tap sequences, checked against a local tempo predictor.
// Depends on tte_pkg and the tap_tempo_estimator RTL.

module tap_tempo_estimator_tb;

    import tte_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam int IDLE_PCT    = 35;
    localparam int SETTLE_CYC  = 120;
    localparam int MAX_PRINTED = 40;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    tap_valid = 1'b0;
    logic                    tap_ready;
    tte_in_t                 tap_item = '0;
    logic                    res_valid;
    logic                    res_ready = 1'b0;
    tte_out_t                res_item;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [GAP_BITS-1:0]     cfg_data = '0;

    // Predictor state: limits, tap history and the tempo in force.
    logic [TEMPO_BITS-1:0] lim_min = TEMPO_MIN_RST;
    logic [TEMPO_BITS-1:0] lim_max = TEMPO_MAX_RST;
    logic [GAP_BITS-1:0]   gap_limit = MAX_GAP_RST;
    logic [TIME_BITS-1:0]  seq_last_time = '0;
    logic [TIME_BITS-1:0]  press_ring [HISTORY_DEPTH];
    int unsigned           ring_slot = 0;
    int unsigned           ring_fill = 0;
    logic [TEMPO_BITS-1:0] tempo_now = TEMPO_RESET;

    tte_out_t tempo_expected [$];
    int       fail_count = 0;
    bit       no_idle = 1'b0;

    tap_tempo_estimator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tap_valid (tap_valid),
        .tap_ready (tap_ready),
        .tap_item  (tap_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
        begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Raise to the minimum first, then lower to the maximum.
    function automatic logic [TEMPO_BITS-1:0] limit_tempo(input logic [63:0] t);
        logic [63:0] v;
        v = t;
        if (v < 64'(lim_min))
        begin
            v = 64'(lim_min);
        end
        if (v > 64'(lim_max))
        begin
            v = 64'(lim_max);
        end
        return v[TEMPO_BITS-1:0];
    endfunction

    function automatic tte_out_t predict_tempo(input tte_in_t it);
        tte_out_t             r;
        logic                 changed;
        logic [TIME_BITS-1:0] gap;
        logic [TIME_BITS-1:0] span;
        logic [TIME_BITS-1:0] avg;
        logic [63:0]          quo;
        int unsigned          oldest;
        changed = 1'b0;
        if (it.mode == MODE_SET)
        begin
            tempo_now = limit_tempo(64'(it.requested_tempo));
            changed = 1'b1;
        end
        else
        begin
            gap = it.tap_time - seq_last_time;
            // A first tap, or one after a long pause, opens a new sequence.
            if (seq_last_time == '0 || gap >= TIME_BITS'(gap_limit))
            begin
                ring_fill = 0;
                ring_slot = 0;
            end
            seq_last_time = it.tap_time;
            press_ring[ring_slot] = it.tap_time;
            ring_slot = (ring_slot + 1) % HISTORY_DEPTH;
            if (ring_fill < HISTORY_DEPTH)
            begin
                ring_fill++;
            end
            if (ring_fill >= 2)
            begin
                oldest = (ring_fill < HISTORY_DEPTH) ? 0 : ring_slot;
                span = it.tap_time - press_ring[oldest];
                avg = span / TIME_BITS'(ring_fill - 1);
                quo = (avg == '0) ? '1 : 64'(MINUTE_US) / 64'(avg);
                tempo_now = limit_tempo(quo);
                changed = 1'b1;
            end
        end
        r.tempo = tempo_now;
        r.tempo_changed = changed;
        r.taps_held = HELD_BITS'(ring_fill);
        return r;
    endfunction

    function automatic logic [TIME_BITS-1:0] rand_time();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mostly intervals that keep the sequence going; now and then exactly the
    // gap limit, which breaks it.
    function automatic logic [TIME_BITS-1:0] pick_interval();
        logic [TIME_BITS-1:0] iv;
        int                   r;
        r = $urandom_range(99, 0);
        if (r < 45)
        begin
            iv = TIME_BITS'($urandom_range(1500000, 150000));
        end
        else if (r < 65)
        begin
            iv = TIME_BITS'($urandom_range(2000, 0));
        end
        else if (r < 96)
        begin
            iv = TIME_BITS'($urandom_range(32'(gap_limit) - 1, 0));
        end
        else
        begin
            iv = TIME_BITS'(gap_limit);
        end
        if (r < 96 && iv >= TIME_BITS'(gap_limit))
        begin
            iv = TIME_BITS'(gap_limit) - TIME_BITS'(1);
        end
        return iv;
    endfunction

    always @(negedge clk)
    begin
        res_ready <= no_idle || ($urandom_range(99, 0) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        tte_out_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (tempo_expected.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending: %p", res_item));
            end
            else
            begin
                want = tempo_expected.pop_front();
                if (res_item.tempo !== want.tempo)
                begin
                    report_mismatch($sformatf("tempo %0d, expected %0d",
                                              res_item.tempo, want.tempo));
                end
                if (res_item.tempo_changed !== want.tempo_changed)
                begin
                    report_mismatch($sformatf("tempo_changed %b, expected %b",
                                              res_item.tempo_changed, want.tempo_changed));
                end
                if (res_item.taps_held !== want.taps_held)
                begin
                    report_mismatch($sformatf("taps_held %0d, expected %0d",
                                              res_item.taps_held, want.taps_held));
                end
            end
        end
    end

    // Called right after an acceptance (or at the start); the first falling
    // edge either loads the next item or lowers valid for an idle stretch.
    task automatic send_item(input tte_in_t it);
        @(negedge clk);
        if (!no_idle && $urandom_range(99, 0) < 3)
        begin
            tap_valid <= 1'b0;
            repeat ($urandom_range(150, 1)) @(negedge clk);
        end
        while (!no_idle && $urandom_range(99, 0) < IDLE_PCT)
        begin
            tap_valid <= 1'b0;
            @(negedge clk);
        end
        tap_item <= it;
        tap_valid <= 1'b1;
        @(posedge clk);
        while (!tap_ready)
        begin
            @(posedge clk);
        end
        tempo_expected.push_back(predict_tempo(it));
    endtask

    task automatic tap_at(input logic [TIME_BITS-1:0] t);
        send_item('{mode: MODE_TAP, tap_time: t, requested_tempo: 16'($urandom)});
    endtask

    task automatic request_tempo(input logic [REQ_BITS-1:0] req);
        send_item('{mode: MODE_SET, tap_time: rand_time(), requested_tempo: req});
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        tap_valid <= 1'b0;
        while (tempo_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [GAP_BITS-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TEMPO_MIN:   lim_min = data[TEMPO_BITS-1:0];
            REG_TEMPO_MAX:   lim_max = data[TEMPO_BITS-1:0];
            REG_MAX_TAP_GAP: gap_limit = data;
            default:         ;
        endcase
    endtask

    // Tempo registers get random bits above their width, which must be dropped.
    task automatic write_limits(input logic [TEMPO_BITS-1:0] tmin,
                                input logic [TEMPO_BITS-1:0] tmax,
                                input logic [GAP_BITS-1:0] gap);
        write_reg(REG_TEMPO_MIN, {14'($urandom), tmin});
        write_reg(REG_TEMPO_MAX, {14'($urandom), tmax});
        write_reg(REG_MAX_TAP_GAP, gap);
    endtask

    task automatic test_direct_set();
        request_tempo(16'd0);
        request_tempo(16'hFFFF);
        request_tempo(16'h5555);
        request_tempo(16'h00AA);
    endtask

    task automatic test_tap_sequences();
        tap_at(48'd0);                  // recorded, but the next tap still restarts
        tap_at(48'd1000000);
        tap_at(48'd1500000);
        tap_at(48'd3500000);            // gap equal to the limit restarts
        tap_at(48'd3500000);            // zero interval saturates to the maximum
        tap_at(48'd5499999);            // gap one below the limit continues
        tap_at(48'd5500009);
        tap_at(48'd100);                // time going backwards restarts
        tap_at(48'hFFFF_FFFF_FF00);
        tap_at(48'h0000_0000_0200);     // continues across the timestamp wrap
    endtask

    task automatic test_register_settings();
        wait_results_done();
        write_limits(10'd0, 10'd1023, 24'hFFFFFF);
        request_tempo(16'd0);
        request_tempo(16'd2000);
        tap_at(48'h8000_0000_0000);
        tap_at(48'h8000_0098_9680);     // ten seconds later: below the old minimum
        tap_at(48'h8000_0198_967E);
        wait_results_done();
        // Minimum above maximum: the maximum wins.
        write_limits(10'd500, 10'd100, 24'd1);
        write_reg(REG_UNUSED, 24'hFFFFFF);
        request_tempo(16'd300);
        tap_at(48'h8000_0198_967E);     // same time, gap zero stays below a limit of one
        tap_at(48'h8000_0198_967F);
    endtask

    task automatic run_traffic(input int n_items);
        int                   sent;
        int                   kind;
        int                   len;
        logic [TIME_BITS-1:0] t;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(99, 0);
            if (kind < 80)
            begin
                t = ($urandom_range(19, 0) == 0) ? '0 : rand_time();
                len = $urandom_range(16, 1);
                for (int k = 0; k < len && sent < n_items; k++)
                begin
                    if (k > 0)
                    begin
                        t = t + pick_interval();
                    end
                    tap_at(t);
                    sent++;
                    if ($urandom_range(9, 0) == 0 && sent < n_items)
                    begin
                        request_tempo(16'($urandom));
                        sent++;
                    end
                end
            end
            else if (kind < 90)
            begin
                request_tempo(16'($urandom));
                sent++;
            end
            else if (kind < 95)
            begin
                tap_at(rand_time());
                sent++;
            end
            else
            begin
                tap_at(seq_last_time - TIME_BITS'($urandom_range(5000, 1)));
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_results_done();
            case (ph)
                0: write_limits(TEMPO_MIN_RST, TEMPO_MAX_RST, MAX_GAP_RST);
                1: write_limits(10'd1, 10'd1023, 24'hFFFFFF);
                2: write_limits(10'd1023, 10'd1, 24'($urandom_range(24'hFFFFFF, 1)));
                default:
                begin
                    write_limits(10'($urandom_range(1023, 1)), 10'($urandom_range(1023, 1)),
                                 24'($urandom_range(24'hFFFFFF, 1)));
                    write_reg(REG_UNUSED, 24'($urandom));
                end
            endcase
            run_traffic(150);
        end
    endtask

    task automatic test_back_to_back();
        wait_results_done();
        write_limits(TEMPO_MIN_RST, TEMPO_MAX_RST, MAX_GAP_RST);
        no_idle = 1'b1;
        run_traffic(150);
        wait_results_done();
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_direct_set();
        test_tap_sequences();
        test_register_settings();
        test_random_traffic();
        test_back_to_back();
        wait_results_done();
        repeat (SETTLE_CYC) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
